// File: design/rcd_pkg.sv
// Shared types, constants and helper functions for the radix conversion block.
package rcd_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned RADIX_W       = 4;
    localparam int unsigned RECIP_W       = 33;
    localparam int unsigned RECIP_SHIFT   = 33;
    localparam int unsigned STACK_DEPTH   = 32;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;

    // Reciprocals floor(2^33 / r), worked out at elaboration.
    localparam logic [RECIP_W-1:0] RECIP_2  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd2);
    localparam logic [RECIP_W-1:0] RECIP_3  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd3);
    localparam logic [RECIP_W-1:0] RECIP_4  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd4);
    localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd5);
    localparam logic [RECIP_W-1:0] RECIP_6  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd6);
    localparam logic [RECIP_W-1:0] RECIP_7  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd7);
    localparam logic [RECIP_W-1:0] RECIP_8  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd8);
    localparam logic [RECIP_W-1:0] RECIP_9  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd9);
    localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic pop;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quot_next_zero;
        logic stack_empty;
    } t_dp_status;

    // Clamp a written radix into the supported range.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [RECIP_W-1:0] radix_recip(input logic [RADIX_W-1:0] r);
        logic [RECIP_W-1:0] res;
        case (r)
            4'd3:    res = RECIP_3;
            4'd4:    res = RECIP_4;
            4'd5:    res = RECIP_5;
            4'd6:    res = RECIP_6;
            4'd7:    res = RECIP_7;
            4'd8:    res = RECIP_8;
            4'd9:    res = RECIP_9;
            4'd10:   res = RECIP_10;
            default: res = RECIP_2;
        endcase
        return res;
    endfunction

endpackage

// File: design/rcd_ctrl.sv
// Controller state machine sequencing division steps and digit output.
module rcd_ctrl
    import rcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.quot_next_zero) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (i_status.stack_empty) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
            end
            ST_READ: begin
                o_cmd.pop = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/rcd_dpath.sv
// Datapath: radix register, reciprocal divider step and the digit stack.
module rcd_dpath
    import rcd_pkg::*;
#(
    parameter int unsigned DIGIT_STACK_DEPTH = STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [RADIX_W-1:0] i_cfg_wr_data,
    input  logic [VALUE_W-1:0] i_value,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_last
);

    localparam int unsigned AW   = $clog2(DIGIT_STACK_DEPTH);
    localparam int unsigned CW   = $clog2(DIGIT_STACK_DEPTH + 1);
    localparam int unsigned PW   = VALUE_W + RECIP_W;
    localparam int unsigned QRW  = VALUE_W + RADIX_W;
    localparam int unsigned REMW = RADIX_W + 1;

    logic [DIGIT_W-1:0] r_stack [DIGIT_STACK_DEPTH];
    logic [RADIX_W-1:0] r_cfg_radix;
    logic [RADIX_W-1:0] r_radix;
    logic [RECIP_W-1:0] r_recip;
    logic [VALUE_W-1:0] r_quot;
    logic [PW-1:0]      r_prod;
    logic [CW-1:0]      r_count;
    logic [DIGIT_W-1:0] r_rd_digit;
    logic               r_last;

    logic [VALUE_W-1:0] w_q_est;
    logic [QRW-1:0]     w_qr;
    logic [VALUE_W-1:0] w_diff;
    logic [REMW-1:0]    w_rem;
    logic               w_ge;
    logic [DIGIT_W-1:0] w_digit;
    logic [VALUE_W-1:0] w_quot_next;
    logic [CW-1:0]      w_top;
    logic               w_room;

    // The estimate from the reciprocal is the true quotient or one below it,
    // so one compare and subtract finishes the step.
    assign w_q_est     = r_prod[PW-1:RECIP_SHIFT];
    assign w_qr        = {{RADIX_W{1'b0}}, w_q_est} * {{VALUE_W{1'b0}}, r_radix};
    assign w_diff      = r_quot - w_qr[VALUE_W-1:0];
    assign w_rem       = w_diff[REMW-1:0];
    assign w_ge        = (w_rem >= {1'b0, r_radix});
    assign w_digit     = w_ge ? DIGIT_W'(w_rem - {1'b0, r_radix}) : w_rem[DIGIT_W-1:0];
    assign w_quot_next = w_q_est + VALUE_W'(w_ge);
    assign w_top       = r_count - CW'(1);
    assign w_room      = (r_count < CW'(DIGIT_STACK_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radix <= RADIX_RESET;
            r_count     <= '0;
            r_quot      <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_radix <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_quot  <= i_value;
                r_count <= '0;
            end else if (i_cmd.div) begin
                r_quot <= w_quot_next;
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_cmd.pop) begin
                r_count <= w_top;
                r_last  <= (w_top == '0);
            end
        end
    end

    // Payload registers and the stack memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix <= eff_radix(r_cfg_radix);
            r_recip <= radix_recip(eff_radix(r_cfg_radix));
        end
        if (i_cmd.mul) begin
            r_prod <= {{RECIP_W{1'b0}}, r_quot} * {{VALUE_W{1'b0}}, r_recip};
        end
        if (i_cmd.div && w_room) begin
            r_stack[r_count[AW-1:0]] <= w_digit;
        end
        if (i_cmd.pop) begin
            r_rd_digit <= r_stack[w_top[AW-1:0]];
        end
    end

    assign o_status.quot_next_zero = (w_quot_next == '0);
    assign o_status.stack_empty    = (r_count == '0);
    assign o_digit                 = r_rd_digit;
    assign o_last                  = r_last;

    // A finished division step leaves a remainder below the radix.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> ({1'b0, w_digit} < {1'b0, r_radix}))
        else $error("digit not below radix");

    // The stack never holds more digits than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DIGIT_STACK_DEPTH))
        else $error("stack count beyond depth");

    // A pop is only issued while digits remain.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from empty stack");

    // Each pop moves the count down by exactly one.
    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop count step wrong");

endmodule

// File: design/radix_conversion_digits_top.sv
// Top level of the radix conversion block: controller and datapath joined.
//
// Each item on the slave side is an unsigned 32-bit value; the block turns it
// into its digits in the configured radix and sends them on the master side
// most significant digit first, one item per digit, with tlast on the least
// significant digit. A value of zero gives the single digit 0. The radix is
// a 4-bit register written through i_cfg_wr_en / i_cfg_wr_data; 0 and 1 act
// as 2 and 11 to 15 act as 10, and the value in force when an item is
// accepted is used for the whole conversion. Only one value is converted at a
// time: s_axis_tready is high only while the block is idle. After a value is
// accepted, each digit takes a division step (a 32 x 33 bit reciprocal
// multiply, then a multiply-back, compare and correct step that pushes the
// remainder onto the digit stack), and the digits are then sent through a stack
// read into the output register and the handshake, which m_axis_tready can
// stall. The division loop through the multiplier and the pop for each digit
// together set the conversion time. If the stack is set shallower than the
// widest result, the more significant digits are dropped and only the
// low-order digits that fit are sent.
module radix_conversion_digits_top
    import rcd_pkg::*;
#(
    parameter int unsigned DIGIT_STACK_DEPTH = STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Radix register write port.
    input  logic               i_cfg_wr_en,
    input  logic [RADIX_W-1:0] i_cfg_wr_data,
    // Input items.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] value
    // Result items.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [3:0] digit, [7:4] zero
    output logic               m_axis_tlast    // last_digit
);

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic [DIGIT_W-1:0] w_digit;

    // The controller walks through accept, the multiply and correct steps of
    // each division, and then pops the stack one digit per result item.
    rcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // The datapath holds the radix register, the running quotient, the
    // reciprocal divider and the digit stack with its count.
    rcd_dpath #(
        .DIGIT_STACK_DEPTH (DIGIT_STACK_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value       (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_digit       (w_digit),
        .o_last        (m_axis_tlast)
    );

    // The digit sits in the low nibble; the upper nibble pads to a byte.
    assign m_axis_tdata = {4'd0, w_digit};

endmodule
